/* rtl/tzpr_pkg.sv */
// ----------------------------------------------------------------------------
// tzpr_pkg
// Shared types, widths and constants of the torus z-buffer point renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package tzpr_pkg;

    // field widths
    localparam int ANG_W     = 16;
    localparam int OP_W      = 2;
    localparam int IDX_W     = 11;
    localparam int CHAR_W    = 8;
    localparam int CLS_W     = 2;
    localparam int SHADE_W   = 4;
    localparam int DEPTH_W   = 16;
    localparam int CELL_W    = DEPTH_W + SHADE_W;
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 16;

    // shared multiplier operand widths
    localparam int MA_W = 24;
    localparam int MB_W = 18;
    localparam int MP_W = MA_W + MB_W;
    localparam int Q_W  = MP_W - 14;

    // division of 2^30 by the depth denominator, one quotient bit a cycle
    localparam int DIV_STEPS = 31;
    localparam int CNT_W     = 5;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 16'hFFFF;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_PLOT  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_SIN_A = 2'd0,
        CFG_COS_A = 2'd1,
        CFG_SIN_B = 2'd2,
        CFG_COS_B = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CLS_EMPTY   = 2'd0,
        CLS_CYAN    = 2'd1,
        CLS_MAGENTA = 2'd2,
        CLS_YELLOW  = 2'd3
    } t_cls;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MULA,
        S_DIV,
        S_MULB,
        S_POS,
        S_ADDR,
        S_UPD,
        S_RDREQ,
        S_RDOUT
    } t_state;

    // one multiply-accumulate step each
    typedef enum logic [4:0] {
        ST_CH, ST_DEN0, ST_DEN1, ST_T0, ST_T1, ST_LH, ST_PX0, ST_PX1,
        ST_PY0, ST_PY1, ST_CD, ST_IN0, ST_IN1, ST_L0, ST_L1, ST_L2,
        ST_LCT, ST_L3, ST_XM, ST_YM
    } t_step;

    typedef struct packed {
        logic  in_ready;
        logic  load;
        logic  step_en;
        t_step step;
        logic  div_init;
        logic  div_en;
        logic  pos_en;
        logic  plot_rd;
        logic  plot_wr;
        logic  clr_en;
        logic  rd_req;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic den_pos;
        logic sweep_last;
        logic in_screen;
        logic out_free;
    } t_stat;

    // shade character for shade index 0..11
    function automatic logic [CHAR_W-1:0] shade_char(input logic [SHADE_W-1:0] s);
        logic [CHAR_W-1:0] c;
        case (s)
            4'd0:    c = 8'h2E;
            4'd1:    c = 8'h2C;
            4'd2:    c = 8'h2D;
            4'd3:    c = 8'h7E;
            4'd4:    c = 8'h3A;
            4'd5:    c = 8'h3B;
            4'd6:    c = 8'h3D;
            4'd7:    c = 8'h21;
            4'd8:    c = 8'h2A;
            4'd9:    c = 8'h23;
            4'd10:   c = 8'h24;
            default: c = 8'h40;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* rtl/torus_zbuffer_point_renderer_unit.sv */
// ----------------------------------------------------------------------------
// torus_zbuffer_point_renderer_unit
// Character framebuffer with depth test, fed one torus surface point a word.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the operation (clear, plot, read), tdata the four
// Q1.14 angle sines/cosines and the cell index. One word is taken at a time;
// tready is high only while the sequencer is idle.
// Clear: sweeps every cell, one per cycle, COLUMNS*ROWS cells (1760 default).
// Plot: 18 multiply steps on the shared 24x18 multiplier, the restoring
// divider for the reciprocal depth, 2 more multiplies, then projection,
// store read and conditional write.
// Read: a store read, then the result word into the output register once free.
// Output stream: one word per read, tdata = char and colour class, tlast marks
// the last column. If the receiver stalls, the result waits in the output
// register; a following read waits for that register, other words go on.
// Configuration: four rotation registers, written any cycle, always ready.
// Reset: registers take their defaults and a clearing pass over all COLUMNS*ROWS
// cells runs, during which no input word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module torus_zbuffer_point_renderer_unit
    import tzpr_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 22
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_s_tvalid,
    output logic                  o_s_tready,
    // [15:0] sin_theta, [31:16] cos_theta, [47:32] sin_phi, [63:48] cos_phi,
    // [74:64] cell_index, [79:75] zero
    input  wire  [S_TDATA_W-1:0]  i_s_tdata,
    // [1:0] operation
    input  wire  [OP_W-1:0]       i_s_tuser,
    output logic                  o_m_tvalid,
    input  wire                   i_m_tready,
    // [7:0] char_code, [9:8] colour_class, [15:10] zero
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    // line_end
    output logic                  o_m_tlast,
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire  [1:0]            i_cfg_index,
    input  wire  [ANG_W-1:0]      i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = cmd.in_ready;

    // sequencer
    tzpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (i_s_tuser),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // arithmetic and stores
    tzpr_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

`default_nettype wire

/* rtl/tzpr_ram.sv */
// ----------------------------------------------------------------------------
// tzpr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tzpr_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1760
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/tzpr_ctrl.sv */
// ----------------------------------------------------------------------------
// tzpr_ctrl
// Sequencer: clear sweep, plot step sequence, divider pacing and cell read.
// ----------------------------------------------------------------------------
`default_nettype none

module tzpr_ctrl
    import tzpr_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire  [1:0]  i_op,
    input  t_stat       i_stat,
    output t_cmd        o_cmd
);

    t_state            r_state, n_state;
    t_step             r_step, n_step;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_step  <= ST_CH;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.step = r_step;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    case (t_op'(i_op))
                        OP_CLEAR: n_state = S_CLEAR;
                        OP_PLOT: begin
                            n_state = S_MULA;
                            n_step  = ST_CH;
                        end
                        OP_READ: n_state = S_RDREQ;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_MULA: begin
                o_cmd.step_en = 1'b1;
                n_step = t_step'(r_step + 5'd1);
                if (r_step == ST_L3) begin
                    o_cmd.div_init = 1'b1;
                    n_cnt = '0;
                    n_state = i_stat.den_pos ? S_DIV : S_IDLE;
                end
            end
            S_DIV: begin
                o_cmd.div_en = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_MULB;
                    n_step  = ST_XM;
                end
            end
            S_MULB: begin
                o_cmd.step_en = 1'b1;
                n_step = ST_YM;
                if (r_step == ST_YM) begin
                    n_state = S_POS;
                end
            end
            S_POS: begin
                o_cmd.pos_en = 1'b1;
                n_state = S_ADDR;
            end
            S_ADDR: begin
                if (i_stat.in_screen) begin
                    o_cmd.plot_rd = 1'b1;
                    n_state = S_UPD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_UPD: begin
                o_cmd.plot_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_RDREQ: begin
                o_cmd.rd_req = 1'b1;
                n_state = S_RDOUT;
            end
            S_RDOUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/tzpr_dp.sv */
// ----------------------------------------------------------------------------
// tzpr_dp
// Datapath: rotation registers, shared multiplier, restoring divider,
// projection, screen stores and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tzpr_dp
    import tzpr_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 22
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  wire  [S_TDATA_W-1:0]  i_s_tdata,
    input  wire                   i_cfg_we,
    input  wire  [1:0]            i_cfg_index,
    input  wire  [ANG_W-1:0]      i_cfg_data,
    input  wire                   i_m_tready,
    output logic                  o_m_tvalid,
    output logic [M_TDATA_W-1:0]  o_m_tdata,
    output logic                  o_m_tlast
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int LQ_SH = 22;
    localparam int LQ_M  = (1 << LQ_SH) / COLUMNS + 1;
    localparam int XV_W  = 44;
    localparam int XP_W  = 40;
    localparam int XY_W  = XV_W - 30;

    // rotation registers
    logic signed [ANG_W-1:0] r_sa, r_ca, r_sb, r_cb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa <= 16'sd0;
            r_ca <= 16'sd16384;
            r_sb <= 16'sd0;
            r_cb <= 16'sd16384;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SIN_A: r_sa <= i_cfg_data;
                CFG_COS_A: r_ca <= i_cfg_data;
                CFG_SIN_B: r_sb <= i_cfg_data;
                CFG_COS_B: r_cb <= i_cfg_data;
                default:   r_sa <= r_sa;
            endcase
        end
    end

    // input word latch
    logic signed [ANG_W-1:0] r_st, r_ct, r_sp, r_cp;
    logic signed [17:0]      r_h;
    logic [IDX_W-1:0]        r_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_st  <= i_s_tdata[15:0];
            r_ct  <= i_s_tdata[31:16];
            r_sp  <= i_s_tdata[47:32];
            r_cp  <= i_s_tdata[63:48];
            r_idx <= i_s_tdata[74:64];
            r_h   <= 18'($signed(i_s_tdata[31:16])) + 18'sd32768;
        end
    end

    // intermediate values
    logic signed [17:0]     r_ch, r_lh, r_cd;
    logic signed [20:0]     r_den, r_t;
    logic signed [21:0]     r_px, r_py, r_lum;
    logic signed [19:0]     r_tmp;
    logic signed [XP_W-1:0] r_xp, r_yp;
    logic [DEPTH_W-1:0]     d16;

    // shared multiplier operand select
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [MP_W-1:0] prod;
    logic signed [Q_W-1:0]  q;

    always_comb begin
        mul_a = MA_W'(r_st);
        mul_b = MB_W'(r_ca);
        case (i_cmd.step)
            ST_CH:   begin mul_a = MA_W'(r_sp);  mul_b = r_h;          end
            ST_DEN0: begin mul_a = MA_W'(r_ch);  mul_b = MB_W'(r_sa);  end
            ST_DEN1: begin mul_a = MA_W'(r_st);  mul_b = MB_W'(r_ca);  end
            ST_T0:   begin mul_a = MA_W'(r_ch);  mul_b = MB_W'(r_ca);  end
            ST_T1:   begin mul_a = MA_W'(r_st);  mul_b = MB_W'(r_sa);  end
            ST_LH:   begin mul_a = MA_W'(r_cp);  mul_b = r_h;          end
            ST_PX0:  begin mul_a = MA_W'(r_lh);  mul_b = MB_W'(r_cb);  end
            ST_PX1:  begin mul_a = MA_W'(r_t);   mul_b = MB_W'(r_sb);  end
            ST_PY0:  begin mul_a = MA_W'(r_lh);  mul_b = MB_W'(r_sb);  end
            ST_PY1:  begin mul_a = MA_W'(r_t);   mul_b = MB_W'(r_cb);  end
            ST_CD:   begin mul_a = MA_W'(r_sp);  mul_b = MB_W'(r_ct);  end
            ST_IN0:  begin mul_a = MA_W'(r_st);  mul_b = MB_W'(r_sa);  end
            ST_IN1:  begin mul_a = MA_W'(r_cd);  mul_b = MB_W'(r_ca);  end
            ST_L0:   begin mul_a = MA_W'(r_tmp); mul_b = MB_W'(r_cb);  end
            ST_L1:   begin mul_a = MA_W'(r_cd);  mul_b = MB_W'(r_sa);  end
            ST_L2:   begin mul_a = MA_W'(r_st);  mul_b = MB_W'(r_ca);  end
            ST_LCT:  begin mul_a = MA_W'(r_cp);  mul_b = MB_W'(r_ct);  end
            ST_L3:   begin mul_a = MA_W'(r_tmp); mul_b = MB_W'(r_sb);  end
            ST_XM:   begin mul_a = MA_W'(r_px);  mul_b = {2'b00, d16}; end
            ST_YM:   begin mul_a = MA_W'(r_py);  mul_b = {2'b00, d16}; end
            default: begin mul_a = MA_W'(r_st);  mul_b = MB_W'(r_ca);  end
        endcase
    end

    // floor of product over 2^14 is the upper product bits
    assign prod = mul_a * mul_b;
    assign q    = prod[MP_W-1:14];

    // multiply-accumulate into the step's destination
    always_ff @(posedge i_clk) begin
        if (i_cmd.step_en) begin
            case (i_cmd.step)
                ST_CH:   r_ch  <= 18'(q);
                ST_DEN0: r_den <= 21'(q + 28'sd81920);
                ST_DEN1: r_den <= 21'(Q_W'(r_den) + q);
                ST_T0:   r_t   <= 21'(q);
                ST_T1:   r_t   <= 21'(Q_W'(r_t) - q);
                ST_LH:   r_lh  <= 18'(q);
                ST_PX0:  r_px  <= 22'(q);
                ST_PX1:  r_px  <= 22'(Q_W'(r_px) - q);
                ST_PY0:  r_py  <= 22'(q);
                ST_PY1:  r_py  <= 22'(Q_W'(r_py) + q);
                ST_CD:   r_cd  <= 18'(q);
                ST_IN0:  r_tmp <= 20'(q);
                ST_IN1:  r_tmp <= 20'(Q_W'(r_tmp) - q);
                ST_L0:   r_lum <= 22'(q);
                ST_L1:   r_lum <= 22'(Q_W'(r_lum) - q);
                ST_L2:   r_lum <= 22'(Q_W'(r_lum) - q);
                ST_LCT:  r_tmp <= 20'(q);
                ST_L3:   r_lum <= 22'(Q_W'(r_lum) - q);
                ST_XM:   r_xp  <= XP_W'(prod);
                ST_YM:   r_yp  <= XP_W'(prod);
                default: r_ch  <= r_ch;
            endcase
        end
    end

    // restoring divider for 2^30 / den
    logic [20:0] r_rem;
    logic [30:0] r_num, r_quo;
    logic [20:0] trial, divisor;

    assign divisor = 21'(r_den);
    assign trial   = {r_rem[19:0], r_num[30]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_num <= 31'h4000_0000;
            r_quo <= '0;
        end else if (i_cmd.div_en) begin
            r_num <= {r_num[29:0], 1'b0};
            if (trial >= divisor) begin
                r_rem <= trial - divisor;
                r_quo <= {r_quo[29:0], 1'b1};
            end else begin
                r_rem <= trial;
                r_quo <= {r_quo[29:0], 1'b0};
            end
        end
    end

    assign d16 = (r_quo > 31'(DEPTH_MAX)) ? DEPTH_MAX : r_quo[DEPTH_W-1:0];

    // screen position and shade, truncated toward zero
    logic signed [XV_W-1:0] vx, vy, xp_w, yp_w;
    logic signed [XY_W-1:0] r_x, r_y, x_fl, y_fl;
    logic [SHADE_W-1:0]     r_shade, shade;

    always_comb begin
        xp_w = XV_W'(r_xp);
        yp_w = XV_W'(r_yp);
        vx = (xp_w <<< 5) - (xp_w <<< 1) + (44'sd40 <<< 30);
        vy = (yp_w <<< 4) - yp_w + (44'sd12 <<< 30);
        x_fl = vx[XV_W-1:30];
        y_fl = vy[XV_W-1:30];
        if (r_lum[21]) begin
            shade = '0;
        end else if (r_lum[20:11] > 10'd11) begin
            shade = 4'd11;
        end else begin
            shade = r_lum[14:11];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pos_en) begin
            r_x <= x_fl + XY_W'(vx[XV_W-1] && (vx[29:0] != '0));
            r_y <= y_fl + XY_W'(vy[XV_W-1] && (vy[29:0] != '0));
            r_shade <= shade;
        end
    end

    logic [AW-1:0] plot_addr;

    assign o_stat.in_screen = (r_x > 14'sd0) && (r_x < $signed(XY_W'(COLUMNS)))
                           && (r_y > 14'sd0) && (r_y < $signed(XY_W'(ROWS)));
    assign plot_addr = AW'(32'(r_x[8:0]) + 32'(COLUMNS) * 32'(r_y[7:0]));
    assign o_stat.den_pos = !r_den[20] && (r_den != '0);

    // clear sweep address
    logic [AW-1:0] r_clr_addr;

    assign o_stat.sweep_last = (r_clr_addr == AW'(CELLS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_addr <= o_stat.sweep_last ? '0 : r_clr_addr + 1'b1;
        end
    end

    // screen store: depth in the upper bits, shade + 1 in the lower
    logic [CELL_W-1:0] rdata, wdata;
    logic [AW-1:0]     waddr, raddr, idx_addr;
    logic [15:0]       idx_ext;
    logic              we, nearer;

    assign idx_ext  = 16'(r_idx);
    assign idx_addr = idx_ext[AW-1:0];
    assign nearer   = d16 > rdata[CELL_W-1:SHADE_W];
    assign we       = i_cmd.clr_en || (i_cmd.plot_wr && nearer);
    assign waddr    = i_cmd.clr_en ? r_clr_addr : plot_addr;
    assign wdata    = i_cmd.clr_en ? '0 : {d16, r_shade + 4'd1};
    assign raddr    = i_cmd.rd_req ? idx_addr : plot_addr;

    tzpr_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (i_cmd.rd_req || i_cmd.plot_rd),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // row quotient of index + 1 for the line-end test
    logic [9:0]  r_lq;
    logic [31:0] lq_prod;

    assign lq_prod = (32'(r_idx) + 32'd1) * 32'(LQ_M);

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_req) begin
            r_lq <= lq_prod[LQ_SH+9:LQ_SH];
        end
    end

    // output register
    logic                 r_out_valid, r_out_last, idx_ok, line_end;
    logic [CHAR_W-1:0]    r_out_char, out_char;
    logic [CLS_W-1:0]     r_out_cls, out_cls;
    logic [SHADE_W-1:0]   s, b;

    assign idx_ok   = idx_ext < 16'(CELLS);
    assign line_end = (32'(r_lq) * 32'(COLUMNS)) == (32'(r_idx) + 32'd1);
    assign s        = rdata[SHADE_W-1:0];
    assign b        = s - 4'd1;

    always_comb begin
        out_char = CHAR_SPACE;
        out_cls  = CLS_EMPTY;
        if (idx_ok && s >= 4'd1 && s <= 4'd12) begin
            out_char = shade_char(b);
            if (b < 4'd4) begin
                out_cls = CLS_CYAN;
            end else if (b < 4'd8) begin
                out_cls = CLS_MAGENTA;
            end else begin
                out_cls = CLS_YELLOW;
            end
        end
    end

    assign o_stat.out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_char <= out_char;
            r_out_cls  <= out_cls;
            r_out_last <= line_end;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_cls, r_out_char};
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

/* rtl/tzpr_checker.sv */
// ----------------------------------------------------------------------------
// tzpr_checker
// Port-level checks of the renderer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tzpr_checker
    import tzpr_pkg::*;
(
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_s_tvalid,
    input wire                  o_s_tready,
    input wire [S_TDATA_W-1:0]  i_s_tdata,
    input wire [OP_W-1:0]       i_s_tuser,
    input wire                  o_m_tvalid,
    input wire                  i_m_tready,
    input wire [M_TDATA_W-1:0]  o_m_tdata,
    input wire                  o_m_tlast,
    input wire                  i_cfg_valid,
    input wire                  o_cfg_ready,
    input wire [1:0]            i_cfg_index,
    input wire [ANG_W-1:0]      i_cfg_data
);

    // reset starts the clearing pass, so no word is taken
    a_rst_no_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("input ready right after reset");

    // reset empties the output register
    a_rst_no_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid right after reset");

    // empty cell reads as a space
    a_empty_space: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[9:8] == CLS_EMPTY) |-> o_m_tdata[7:0] == CHAR_SPACE)
        else $error("empty cell with a shade character");

    // drawn cell never reads as a space
    a_drawn_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[9:8] != CLS_EMPTY) |-> o_m_tdata[7:0] != CHAR_SPACE)
        else $error("drawn cell reads as a space");

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tlast)))
        else $error("output word changed under stall");

endmodule

bind torus_zbuffer_point_renderer_unit tzpr_checker u_tzpr_checker (.*);

`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the torus z-buffer point renderer. A scoreboard
// class mirrors the depth and shade stores and the rotation registers,
// predicts every read word and compares it with the output stream. Stimulus
// is a directed opening, then phases of rotation settings, each with a clear,
// corner plots and random torus points mixed with reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    import tzpr_pkg::*;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 22;
    localparam int CELLS      = COLUMNS * ROWS;
    localparam int ONE        = 16384;
    localparam int DRAIN_CYC  = 2000;
    localparam int CYCLE_LIM  = 1500000;
    localparam int RAND_ITEMS = 170;
    localparam int PHASES     = 6;

    typedef struct {
        logic [CHAR_W-1:0] char_code;
        logic [CLS_W-1:0]  colour;
        logic              line_end;
    } t_cell_word;

    // mirror of the renderer state and predicted read words
    class cell_scoreboard;
        longint          sin_a, cos_a, sin_b, cos_b;
        logic [15:0]     depth_mem[CELLS];
        logic [3:0]      shade_mem[CELLS];
        t_cell_word      read_q[$];
        int              errors;
        string           shade_str;

        function void init();
            sin_a = 0;
            cos_a = ONE;
            sin_b = 0;
            cos_b = ONE;
            errors = 0;
            shade_str = ".,-~:;=!*#$@";
            wipe();
        endfunction

        function void wipe();
            for (int i = 0; i < CELLS; i++) begin
                depth_mem[i] = '0;
                shade_mem[i] = '0;
            end
        endfunction

        function void set_reg(t_cfg_idx idx, logic [15:0] v);
            longint sv;
            sv = longint'($signed(v));
            case (idx)
                CFG_SIN_A: sin_a = sv;
                CFG_COS_A: cos_a = sv;
                CFG_SIN_B: sin_b = sv;
                default:   cos_b = sv;
            endcase
        endfunction

        // q1.14 product, floored
        function longint qm(longint a, longint b);
            return (a * b) >>> 14;
        endfunction

        function void plot(longint st, longint ct, longint sp, longint cp);
            longint h, ch, den, d16, t, lh, px, py, x, y, cd, lum, shade, cell_pos;
            h = ct + 2 * ONE;
            ch = qm(sp, h);
            den = qm(ch, sin_a) + qm(st, cos_a) + 5 * ONE;
            if (den <= 0) return;
            d16 = (longint'(1) << 30) / den;
            if (d16 > 65535) d16 = 65535;
            t = qm(ch, cos_a) - qm(st, sin_a);
            lh = qm(cp, h);
            px = qm(lh, cos_b) - qm(t, sin_b);
            py = qm(lh, sin_b) + qm(t, cos_b);
            x = (40 * (longint'(1) << 30) + 30 * d16 * px) / (longint'(1) << 30);
            y = (12 * (longint'(1) << 30) + 15 * d16 * py) / (longint'(1) << 30);
            cd = qm(sp, ct);
            lum = qm(qm(st, sin_a) - qm(cd, cos_a), cos_b)
                - qm(cd, sin_a) - qm(st, cos_a) - qm(qm(cp, ct), sin_b);
            shade = (8 * lum) / ONE;
            if (shade < 0) shade = 0;
            if (shade > 11) shade = 11;
            if (!(y > 0 && y < ROWS && x > 0 && x < COLUMNS)) return;
            cell_pos = x + COLUMNS * y;
            if (d16 > longint'(depth_mem[cell_pos])) begin
                depth_mem[cell_pos] = d16[15:0];
                shade_mem[cell_pos] = 4'(shade + 1);
            end
        endfunction

        // called for every accepted input word
        function void note_word(t_op op, logic [S_TDATA_W-1:0] d);
            t_cell_word w;
            int         idx;
            case (op)
                OP_CLEAR: wipe();
                OP_PLOT:  plot(longint'($signed(d[15:0])), longint'($signed(d[31:16])),
                               longint'($signed(d[47:32])), longint'($signed(d[63:48])));
                OP_READ: begin
                    idx = int'(d[74:64]);
                    w.char_code = CHAR_SPACE;
                    w.colour = CLS_EMPTY;
                    if (idx < CELLS && shade_mem[idx] != 0) begin
                        w.char_code = shade_str[shade_mem[idx] - 1];
                        w.colour = (shade_mem[idx] <= 4) ? CLS_CYAN :
                                   (shade_mem[idx] <= 8) ? CLS_MAGENTA : CLS_YELLOW;
                    end
                    w.line_end = (idx % COLUMNS) == COLUMNS - 1;
                    read_q.push_back(w);
                end
                default: ;
            endcase
        endfunction

        function void check_word(logic [M_TDATA_W-1:0] d, logic last);
            t_cell_word w;
            if (read_q.size() == 0) begin
                $display("%0t: unexpected word, actual %h last %b", $time, d, last);
                errors++;
                return;
            end
            w = read_q.pop_front();
            if (d[7:0] !== w.char_code) begin
                $display("%0t: char mismatch, expected %h actual %h",
                         $time, w.char_code, d[7:0]);
                errors++;
            end
            if (d[9:8] !== w.colour) begin
                $display("%0t: colour mismatch, expected %0d actual %0d",
                         $time, w.colour, d[9:8]);
                errors++;
            end
            if (last !== w.line_end) begin
                $display("%0t: line end mismatch, expected %b actual %b",
                         $time, w.line_end, last);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0]      s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [1:0]           cfg_index = '0;
    logic [ANG_W-1:0]     cfg_data = '0;

    cell_scoreboard sb;
    bit             quiet = 1'b0;
    int             cycles = 0;

    always #5 i_clk = ~i_clk;

    torus_zbuffer_point_renderer_unit #(.COLUMNS(COLUMNS), .ROWS(ROWS)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    // result side: check accepted words, stall at random unless quiet
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast);
        m_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 20);
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIM) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // one input word, at random with a gap ahead of it unless quiet
    task automatic send_word(t_op op, logic [15:0] st, logic [15:0] ct,
                             logic [15:0] sp, logic [15:0] cp, logic [10:0] idx);
        if (!quiet && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {5'b0, idx, cp, sp, ct, st};
        do @(posedge i_clk); while (!(s_tready && s_tvalid));
        sb.note_word(op, s_tdata);
    endtask

    // let every expected word arrive and the sequencer settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.read_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_rotation(logic [15:0] sa, logic [15:0] ca,
                                  logic [15:0] sb_v, logic [15:0] cb);
        logic [15:0] vals[4];
        vals = '{sa, ca, sb_v, cb};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data <= vals[i];
            do @(posedge i_clk); while (!(cfg_ready && cfg_valid));
            sb.set_reg(t_cfg_idx'(i), vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] q14(real v);
        return 16'($rtoi(v * ONE));
    endfunction

    // full-scale and out-of-range points: clamping, bad denominators
    task automatic corner_plots();
        send_word(OP_PLOT, 16'h4000, 16'h4000, 16'h4000, 16'h4000, '0);
        send_word(OP_PLOT, 16'hC000, 16'hC000, 16'hC000, 16'hC000, '0);
        send_word(OP_PLOT, 16'h0000, 16'h0000, 16'h0000, 16'h0000, '0);
        send_word(OP_PLOT, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, '0);
        send_word(OP_PLOT, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, '0);
        send_word(OP_PLOT, 16'hB000, 16'h7FFF, 16'hD000, 16'h2000, '0);
    endtask

    task automatic random_item();
        int   pick;
        real  th, ph;
        pick = $urandom_range(99);
        th = $urandom_range(0, 6283) / 1000.0;
        ph = $urandom_range(0, 6283) / 1000.0;
        if (pick < 2)
            send_word(OP_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 11'($urandom));
        else if (pick < 4)
            send_word(OP_NONE, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 11'($urandom));
        else if (pick < 8)
            send_word(OP_PLOT, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 11'($urandom));
        else if (pick < 60)
            send_word(OP_PLOT, q14($sin(th)), q14($cos(th)), q14($sin(ph)),
                      q14($cos(ph)), 11'($urandom));
        else if (pick < 95)
            send_word(OP_READ, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 11'($urandom_range(0, CELLS - 1)));
        else
            send_word(OP_READ, '0, '0, '0, '0, 11'($urandom_range(0, 2047)));
    endtask

    initial begin
        real ra, rb;
        sb = new();
        sb.init();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed opening with reset rotation
        send_word(OP_READ, '0, '0, '0, '0, 11'd0);
        corner_plots();
        for (int i = 0; i < 8; i++) begin
            send_word(OP_PLOT, q14($sin(i * 0.8)), q14($cos(i * 0.8)),
                      q14($sin(i * 0.4)), q14($cos(i * 0.4)), '0);
        end
        send_word(OP_READ, '0, '0, '0, '0, 11'd79);
        send_word(OP_READ, '0, '0, '0, '0, 11'd1759);
        send_word(OP_READ, '0, '0, '0, '0, 11'd1760);
        send_word(OP_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 11'd2047);
        send_word(OP_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 11'd2047);
        send_word(OP_CLEAR, '0, '0, '0, '0, '0);
        send_word(OP_READ, '0, '0, '0, '0, 11'd840);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: write_rotation(16'h4000, 16'h0000, 16'h4000, 16'h0000);
                1: write_rotation(16'hC000, 16'h0000, 16'hC000, 16'h0000);
                2: write_rotation(16'h0000, 16'hC000, 16'h0000, 16'hC000);
                3: write_rotation(16'h0000, 16'h4000, 16'h0000, 16'h4000);
                default: begin
                    ra = $urandom_range(0, 6283) / 1000.0;
                    rb = $urandom_range(0, 6283) / 1000.0;
                    write_rotation(q14($sin(ra)), q14($cos(ra)), q14($sin(rb)), q14($cos(rb)));
                end
            endcase
            quiet = (p == 2);
            send_word(OP_CLEAR, '0, '0, '0, '0, '0);
            corner_plots();
            for (int i = 0; i < RAND_ITEMS; i++) begin
                if (p == 4 && i == RAND_ITEMS / 2) begin
                    s_tvalid <= 1'b0;
                    while (sb.read_q.size() != 0) @(posedge i_clk);
                end
                random_item();
            end
            quiet = 1'b0;
        end

        drain();
        if (sb.errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
